// ===== rtl/vrra_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable record ring allocator package
// Shared widths, command codes, limits and beat types for the ring
// allocator, its checker and its testbench.
// ----------------------------------------------------------------------------
package vrra_pkg;

  // Field widths.
  localparam int OFS_W  = 13;
  localparam int SIZE_W = 12;
  localparam int CNT_W  = 10;
  localparam int USE_W  = 8;
  localparam int OP_W   = 3;

  // Defaults for the top-level parameters.
  localparam int BUF_BYTES_DEF    = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  // Reset value of the ring size register.
  localparam logic [OFS_W-1:0] TOTAL_SIZE_RST = 13'd4096;

  // Saturation limits.
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [USE_W-1:0] USE_MAX   = 8'd255;

  // Command codes.
  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_PURGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Command beat.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SIZE_W-1:0] size;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic              status;
    logic [OFS_W-1:0]  payload_offset;
    logic [SIZE_W-1:0] item_size;
    logic [CNT_W-1:0]  item_count;
    logic              in_use;
  } out_item_t;

  // One record header as kept in the header RAM.
  typedef struct packed {
    logic [OFS_W-1:0]  link;
    logic [SIZE_W-1:0] size;
  } hdr_t;

endpackage

// ===== rtl/vrra_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered, no reset.
// ----------------------------------------------------------------------------
module vrra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/variable_record_ring_allocator.sv =====
// Get, peek, clear, undefined codes and puts refused on a full count give their result
// in the cycle after the command beat, and the next command is taken in that same cycle
// (one per cycle). Purge waits for the new head header from the header RAM's registered
// read. Put walks up to three fit steps on the shared add/compare unit, then the header
// RAM's single write port stores up to two headers, one per cycle.
// Reset is synchronous and clears all control state; the header RAM is not cleared.
// ----------------------------------------------------------------------------
// Variable record ring allocator
// Keeps a FIFO of variable-size records in a byte ring. Each record has a
// header (link to the next offset, payload size) stored in a header RAM.
// ----------------------------------------------------------------------------
module variable_record_ring_allocator
  import vrra_pkg::*;
#(
  parameter int BUF_BYTES    = BUF_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [OFS_W-1:0] cfg_data
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int HW = $bits(hdr_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIT0  = 3'd1;
  localparam logic [2:0] S_FIT1  = 3'd2;
  localparam logic [2:0] S_FIT2  = 3'd3;
  localparam logic [2:0] S_WTAIL = 3'd4;
  localparam logic [2:0] S_WNEW  = 3'd5;
  localparam logic [2:0] S_PLOAD = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [OFS_W-1:0]  need_r, need_nxt;
  logic              wrap_r, wrap_nxt;
  logic [OFS_W-1:0]  place_r, place_nxt;
  logic [OFS_W-1:0]  head_r, head_nxt;
  logic [OFS_W-1:0]  tail_r, tail_nxt;
  logic [OFS_W-1:0]  nf_r, nf_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [USE_W-1:0]  use_r, use_nxt;
  logic [OFS_W-1:0]  head_link_r, head_link_nxt;
  logic [SIZE_W-1:0] head_size_r, head_size_nxt;
  logic [SIZE_W-1:0] tail_size_r, tail_size_nxt;
  logic [OFS_W-1:0]  total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              accept;
  logic              empty;
  logic [OFS_W-1:0]  bound;

  // Shared add/compare unit.
  logic [OFS_W-1:0]  add_x;
  logic [OFS_W-1:0]  add_y;
  logic [OFS_W-1:0]  cmp_b;
  logic [OFS_W:0]    sum;
  logic              le;

  // Header RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  hdr_t              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  hdr_t              ram_rdata;
  logic [HW-1:0]     ram_rdata_raw;

  // Map a byte offset to its header RAM entry; offsets past the end alias entry zero.
  function automatic logic [AW-1:0] slot_of(input logic [OFS_W-1:0] ofs);
    slot_of = (32'(ofs) < 32'(BUF_BYTES)) ? AW'(ofs) : '0;
  endfunction

  // Assemble a result beat; the head size reads as zero on an empty queue.
  function automatic out_item_t make_resp(input logic              st,
                                          input logic [OFS_W-1:0]  pofs,
                                          input logic [SIZE_W-1:0] hsize,
                                          input logic [CNT_W-1:0]  cnt,
                                          input logic [USE_W-1:0]  uc);
    out_item_t r;
    r.status         = st;
    r.payload_offset = pofs;
    r.item_size      = (cnt != '0) ? hsize : '0;
    r.item_count     = cnt;
    r.in_use         = (uc != '0);
    make_resp = r;
  endfunction

  assign accept    = start && !busy;
  assign empty     = (count_r == '0);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Ring bound is the smaller of the size register and the buffer.
  assign bound = (32'(total_r) < 32'(BUF_BYTES)) ? total_r : OFS_W'(BUF_BYTES);

  // Operand selection for the shared unit, one use per sequencer step.
  always_comb begin
    add_x = '0;
    add_y = '0;
    cmp_b = '0;
    case (state_r)
      S_FIT0: begin
        add_x = nf_r;
        cmp_b = head_r;
      end
      S_FIT1: begin
        add_x = nf_r;
        add_y = need_r;
        cmp_b = (empty || !wrap_r) ? bound : head_r;
      end
      S_FIT2: begin
        add_x = need_r;
        add_y = empty ? OFS_W'(0) : OFS_W'(1);
        cmp_b = empty ? bound : head_r;
      end
      S_WNEW: begin
        add_x = place_r;
        add_y = need_r;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y};
  assign le  = (sum <= {1'b0, cmp_b});

  // Purge reads the header of the record that becomes the head.
  assign ram_raddr = slot_of(head_link_r);
  assign ram_rdata = hdr_t'(ram_rdata_raw);

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    need_nxt      = need_r;
    wrap_nxt      = wrap_r;
    place_nxt     = place_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nf_nxt        = nf_r;
    count_nxt     = count_r;
    use_nxt       = use_r;
    head_link_nxt = head_link_r;
    head_size_nxt = head_size_r;
    tail_size_nxt = tail_size_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_of(place_r);
    ram_wdata     = '{link: sum[OFS_W-1:0], size: size_r};

    if (cfg_valid && cfg_ready) begin
      total_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          size_nxt = in_data.size;
          need_nxt = OFS_W'(HEADER_BYTES) + OFS_W'(in_data.size);
          case (in_data.opcode)
            OP_PUT: begin
              if (count_r == COUNT_MAX) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_resp(1'b1, '0, head_size_r, count_r, use_r);
              end else begin
                state_nxt = S_FIT0;
              end
            end
            OP_GET, OP_PEEK: begin
              if (empty) begin
                out_nxt = make_resp(1'b1, '0, head_size_r, count_r, use_r);
              end else begin
                if (in_data.opcode == OP_GET && use_r != USE_MAX) begin
                  use_nxt = use_r + USE_W'(1);
                end
                out_nxt = make_resp(1'b0, head_r + OFS_W'(HEADER_BYTES),
                                    head_size_r, count_r, use_nxt);
              end
              out_valid_nxt = 1'b1;
            end
            OP_PURGE: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_resp(1'b1, '0, head_size_r, count_r, use_r);
              end else begin
                if (use_r != '0) begin
                  use_nxt = use_r - USE_W'(1);
                end
                head_nxt  = head_link_r;
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_PLOAD;
              end
            end
            OP_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              nf_nxt        = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = make_resp(1'b0, '0, '0, '0, use_r);
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt = make_resp(1'b1, '0, head_size_r, count_r, use_r);
            end
          endcase
        end
      end

      // The ring is wrapped when the free point sits at or below the head.
      S_FIT0: begin
        wrap_nxt  = le;
        state_nxt = S_FIT1;
      end

      // Try the free point first.
      S_FIT1: begin
        if (le) begin
          place_nxt = nf_r;
          state_nxt = S_WNEW;
        end else if (!empty && wrap_r) begin
          out_valid_nxt = 1'b1;
          out_nxt   = make_resp(1'b1, '0, head_size_r, count_r, use_r);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIT2;
        end
      end

      // Then try offset zero, below the head when the queue holds records.
      S_FIT2: begin
        if (le) begin
          place_nxt = '0;
          state_nxt = empty ? S_WNEW : S_WTAIL;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt   = make_resp(1'b1, '0, head_size_r, count_r, use_r);
          state_nxt = S_IDLE;
        end
      end

      // On a wrap the tail record now links to offset zero.
      S_WTAIL: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(tail_r);
        ram_wdata = '{link: '0, size: tail_size_r};
        if (count_r == CNT_W'(1)) begin
          head_link_nxt = '0;
        end
        state_nxt = S_WNEW;
      end

      // Store the new header and advance the tail.
      S_WNEW: begin
        ram_we        = 1'b1;
        ram_waddr     = slot_of(place_r);
        ram_wdata     = '{link: sum[OFS_W-1:0], size: size_r};
        tail_nxt      = place_r;
        tail_size_nxt = size_r;
        nf_nxt        = sum[OFS_W-1:0];
        count_nxt     = count_r + CNT_W'(1);
        if (empty) begin
          head_nxt      = place_r;
          head_link_nxt = sum[OFS_W-1:0];
          head_size_nxt = size_r;
        end
        out_valid_nxt = 1'b1;
        out_nxt = make_resp(1'b0, place_r + OFS_W'(HEADER_BYTES),
                            empty ? size_r : head_size_r, count_nxt, use_r);
        state_nxt = S_IDLE;
      end

      // The new head header has arrived from the RAM.
      S_PLOAD: begin
        head_size_nxt = ram_rdata.size;
        head_link_nxt = ram_rdata.link;
        out_valid_nxt = 1'b1;
        out_nxt   = make_resp(1'b0, '0, ram_rdata.size, count_r, use_r);
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wrap_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      nf_r        <= '0;
      count_r     <= '0;
      use_r       <= '0;
      head_link_r <= '0;
      head_size_r <= '0;
      tail_size_r <= '0;
      total_r     <= TOTAL_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wrap_r      <= wrap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nf_r        <= nf_nxt;
      count_r     <= count_nxt;
      use_r       <= use_nxt;
      head_link_r <= head_link_nxt;
      head_size_r <= head_size_nxt;
      tail_size_r <= tail_size_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    need_r  <= need_nxt;
    place_r <= place_nxt;
    out_r   <= out_nxt;
  end

  // Header store.
  vrra_ram #(
    .WIDTH (HW),
    .DEPTH (BUF_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (HW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

endmodule

// ===== rtl/vrra_checker.sv =====
// ----------------------------------------------------------------------------
// Variable record ring allocator checker
// Port-level assertions on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module vrra_checker
  import vrra_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  logic accept;
  assign accept = start && !busy;

  // Short commands answer in the next cycle; undefined codes sit above clear.
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.opcode == OP_GET || in_data.opcode == OP_PEEK ||
               in_data.opcode == OP_CLEAR || in_data.opcode > OP_CLEAR) |=> out_valid)
    else $error("short command gave no result beat in the next cycle");

  // Clear always succeeds and leaves an empty queue.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.opcode == OP_CLEAR |=>
      out_valid && !out_data.status && out_data.item_count == '0)
    else $error("clear did not report an empty queue");

  // An empty queue reports no head size.
  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_count == '0 |-> out_data.item_size == '0)
    else $error("nonzero item size on an empty queue");

  // A result beat is shown only once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("block not idle after reset");

endmodule

bind variable_record_ring_allocator vrra_checker u_vrra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/tb_variable_record_ring_allocator.sv =====
// ----------------------------------------------------------------------------
// Variable record ring allocator testbench
// Sends put, get, peek, purge, clear and undefined commands to the allocator.
// A scoreboard keeps its own copy of the ring state and header store, works
// out the result of each accepted command, and compares every result beat
// field by field. The ring size register is changed between phases. The
// sender idles at one of three rates, chosen per phase.
// ----------------------------------------------------------------------------
module tb_variable_record_ring_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import vrra_pkg::*;

  localparam int unsigned SIZE_LIMIT  = BUF_BYTES_DEF - HEADER_BYTES_DEF;
  localparam logic [OP_W-1:0] OP_LAST = '1;
  localparam int PHASES         = 8;
  localparam int PHASE_CMDS     = 200;
  localparam int USE_BURST      = 270;
  localparam int SETTLE_CYCLES  = 20;

  // Scoreboard: mirror of the ring state and the queue of awaited results.
  class ring_tracker;
    logic [OFS_W-1:0]  hdr_link [BUF_BYTES_DEF];
    logic [SIZE_W-1:0] hdr_size [BUF_BYTES_DEF];
    int unsigned ring_size = TOTAL_SIZE_RST;
    int unsigned head_offset;
    int unsigned tail_offset;
    int unsigned next_free;
    int unsigned record_count;
    int unsigned use_count;
    out_item_t   awaited_replies[$];
    int          error_count;

    function int unsigned slot(int unsigned ofs);
      return (ofs < BUF_BYTES_DEF) ? ofs : 0;
    endfunction

    function int unsigned ring_bound();
      return (ring_size < BUF_BYTES_DEF) ? ring_size : BUF_BYTES_DEF;
    endfunction

    // Apply one accepted command beat and queue the result it must produce.
    function void apply_command(in_item_t cmd);
      out_item_t   want;
      int unsigned need;
      int unsigned bound;
      int unsigned spot;
      bit          placed;
      want = '0;
      want.status = 1'b1;
      need = HEADER_BYTES_DEF + cmd.size;
      bound = ring_bound();
      spot = 0;
      placed = 1'b0;
      case (cmd.opcode)
        OP_PUT: begin
          // Fit test: empty ring, unwrapped ring, or wrapped ring.
          if (record_count >= COUNT_MAX) begin
            placed = 1'b0;
          end else if (record_count == 0) begin
            if (next_free + need <= bound) begin
              spot = next_free;
              placed = 1'b1;
            end else if (need <= bound) begin
              spot = 0;
              placed = 1'b1;
            end
            if (placed) head_offset = spot;
          end else if (next_free > head_offset) begin
            if (next_free + need <= bound) begin
              spot = next_free;
              placed = 1'b1;
            end else if (need < head_offset) begin
              // Wrap to the start: the tail record now links to offset zero.
              spot = 0;
              placed = 1'b1;
              hdr_link[slot(tail_offset)] = '0;
            end
          end else if (next_free + need <= head_offset) begin
            spot = next_free;
            placed = 1'b1;
          end
          if (placed) begin
            hdr_link[slot(spot)] = OFS_W'(spot + need);
            hdr_size[slot(spot)] = cmd.size;
            tail_offset = spot;
            next_free = spot + need;
            record_count++;
            want.status = 1'b0;
            want.payload_offset = OFS_W'(spot + HEADER_BYTES_DEF);
          end
        end
        OP_GET, OP_PEEK: begin
          if (record_count > 0) begin
            if (cmd.opcode == OP_GET && use_count < USE_MAX) use_count++;
            want.status = 1'b0;
            want.payload_offset = OFS_W'(head_offset + HEADER_BYTES_DEF);
          end
        end
        OP_PURGE: begin
          if (record_count > 0) begin
            if (use_count > 0) use_count--;
            head_offset = hdr_link[slot(head_offset)];
            record_count--;
            want.status = 1'b0;
          end
        end
        OP_CLEAR: begin
          head_offset = 0;
          tail_offset = 0;
          next_free = 0;
          record_count = 0;
          want.status = 1'b0;
        end
        default: begin
        end
      endcase
      want.item_size  = (record_count > 0) ? hdr_size[slot(head_offset)] : '0;
      want.item_count = CNT_W'(record_count);
      want.in_use     = (use_count != 0);
      awaited_replies.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    // Compare one result beat with the oldest awaited result.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (awaited_replies.size() == 0) begin
        $error("result beat with nothing awaited: %p", got);
        error_count++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("item_size", want.item_size, got.item_size);
      compare_field("item_count", want.item_count, got.item_count);
      compare_field("in_use", want.in_use, got.in_use);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_data = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [OFS_W-1:0] cfg_data = '0;

  ring_tracker sb = new();

  variable_record_ring_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result monitor: every strobed beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_reply(out_data);
  end

  function automatic in_item_t mk_cmd(logic [OP_W-1:0] op, int unsigned sz);
    in_item_t c;
    c.opcode = op;
    c.size = SIZE_W'(sz);
    return c;
  endfunction

  // Mostly puts and purges so the ring fills, wraps and drains.
  function automatic in_item_t random_cmd(int unsigned bound);
    in_item_t    c;
    int unsigned pick;
    int unsigned cap;
    pick = $urandom_range(99);
    c.size = SIZE_W'($urandom_range(SIZE_LIMIT));
    if (pick < 42) begin
      c.opcode = OP_PUT;
      pick = $urandom_range(99);
      if (pick < 60) cap = bound / 16;
      else if (pick < 88) cap = bound / 4;
      else cap = SIZE_LIMIT;
      if (cap < HEADER_BYTES_DEF) cap = HEADER_BYTES_DEF;
      if (cap > SIZE_LIMIT) cap = SIZE_LIMIT;
      c.size = SIZE_W'($urandom_range(cap));
    end else if (pick < 74) begin
      c.opcode = OP_PURGE;
    end else if (pick < 84) begin
      c.opcode = OP_GET;
    end else if (pick < 92) begin
      c.opcode = OP_PEEK;
    end else if (pick < 95) begin
      c.opcode = OP_CLEAR;
    end else begin
      c.opcode = OP_W'($urandom_range(OP_LAST, OP_CLEAR + 1));
    end
    return c;
  endfunction

  // Send one command beat; called and returning at a falling edge.
  task automatic send_cmd(in_item_t cmd, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    sb.apply_command(cmd);
    @(negedge clk);
  endtask

  // Stop sending and wait until every awaited result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the ring size register while the block is idle.
  task automatic write_ring_size(int unsigned value);
    cfg_valid <= 1'b1;
    cfg_data <= OFS_W'(value);
    do @(posedge clk); while (!cfg_ready);
    sb.ring_size = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned ring_sizes [PHASES] = '{16, 300, 4096, 1024, 17, 4095, 0, 2048};
    int unsigned idle_pct;
    int unsigned ring;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_ring_size(TOTAL_SIZE_RST);

    // Directed: empty-queue failures, undefined codes, full-ring record,
    // puts refused at the ring end, purges and clears.
    send_cmd(mk_cmd(OP_GET, 0), 0);
    send_cmd(mk_cmd(OP_PEEK, SIZE_LIMIT), 0);
    send_cmd(mk_cmd(OP_PURGE, 0), 0);
    send_cmd(mk_cmd(OP_W'(OP_CLEAR + 1), 0), 0);
    send_cmd(mk_cmd(OP_W'(OP_CLEAR + 2), 0), 0);
    send_cmd(mk_cmd(OP_LAST, SIZE_LIMIT), 0);
    send_cmd(mk_cmd(OP_PUT, SIZE_LIMIT), 0);
    send_cmd(mk_cmd(OP_PUT, 0), 0);
    send_cmd(mk_cmd(OP_GET, 0), 0);
    send_cmd(mk_cmd(OP_PEEK, 0), 0);
    send_cmd(mk_cmd(OP_PURGE, 0), 0);
    send_cmd(mk_cmd(OP_PUT, 0), 0);
    send_cmd(mk_cmd(OP_CLEAR, 0), 0);
    send_cmd(mk_cmd(OP_PUT, 100), 0);
    send_cmd(mk_cmd(OP_PUT, 200), 0);
    send_cmd(mk_cmd(OP_PUT, 3000), 0);
    send_cmd(mk_cmd(OP_PUT, 1000), 0);
    send_cmd(mk_cmd(OP_PURGE, 0), 0);
    send_cmd(mk_cmd(OP_PUT, 50), 0);
    send_cmd(mk_cmd(OP_PUT, 40), 0);
    send_cmd(mk_cmd(OP_PUT, 0), 0);
    send_cmd(mk_cmd(OP_PURGE, 0), 0);
    send_cmd(mk_cmd(OP_PURGE, 0), 0);
    send_cmd(mk_cmd(OP_GET, 0), 0);
    send_cmd(mk_cmd(OP_CLEAR, 0), 0);
    drain();

    // Random phases, each with its own ring size and sender idle rate.
    for (int p = 0; p < PHASES; p++) begin
      ring = (ring_sizes[p] == 0) ? $urandom_range(4096, 16) : ring_sizes[p];
      write_ring_size(ring);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 73;
        default: idle_pct = 9;
      endcase
      if (p == 2) begin
        // Long run of gets pushes the use count into saturation.
        send_cmd(mk_cmd(OP_PUT, 4), idle_pct);
        repeat (USE_BURST) send_cmd(mk_cmd(OP_GET, $urandom_range(SIZE_LIMIT)), idle_pct);
      end
      repeat (PHASE_CMDS) send_cmd(random_cmd(sb.ring_bound()), idle_pct);
      drain();
    end

    if (sb.error_count == 0 && sb.awaited_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vrra_pkg.sv
rtl/vrra_ram.sv
rtl/variable_record_ring_allocator.sv
rtl/vrra_checker.sv
sim/tb_variable_record_ring_allocator.sv
